// ===== rtl/core/ipba_pkg.sv =====
// ----------------------------------------------------------------------------
// ipba_pkg
// Shared types and codes for the IP address and port byte accounting block.
// ----------------------------------------------------------------------------
package ipba_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OWN_IP_ADDR      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_CHECK_ENABLE = 1'd1;

	localparam logic OP_ACCOUNT = 1'b0;
	localparam logic OP_EXPORT  = 1'b1;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_ADDR  = 2'd0;
	localparam kind_t KIND_PORT  = 2'd1;
	localparam kind_t KIND_EMPTY = 2'd2;

	typedef struct packed {
		logic        operation;
		logic [31:0] src_ip_addr;
		logic [31:0] dst_ip_addr;
		logic [15:0] src_tcp_port;
		logic [15:0] dst_tcp_port;
		logic [15:0] payload_len;
	} in_word_t;

	typedef struct packed {
		kind_t       record_kind;
		logic [31:0] record_key;
		logic [31:0] byte_total;
		logic        last;
	} out_word_t;

endpackage

// ===== rtl/core/ipba_stream_if.sv =====
// ----------------------------------------------------------------------------
// ipba_stream_if
// Valid/ready stream channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface ipba_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/ip_port_byte_accounting.sv =====
// ----------------------------------------------------------------------------
// ip_port_byte_accounting
// Per-packet byte accounting over an address table and a port table.
// ----------------------------------------------------------------------------
// Account word: accept, then a lookup and a count write-back step for the
// source and then the destination keys, both tables in parallel, as the
// count memories have a registered read. Export word: each record is read,
// then loaded into the output stage, which waits while records are stalled.
// Skipped account words do no lookup. Reset clears the fill counts, the state
// and the output stage; the tables need no clearing pass.
// ----------------------------------------------------------------------------
module ip_port_byte_accounting import ipba_pkg::*; #(
	parameter int ADDR_ENTRIES = 16,
	parameter int PORT_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ipba_stream_if.sink           items,
	ipba_stream_if.source         records,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	localparam int AIW = $clog2(ADDR_ENTRIES);
	localparam int ACW = $clog2(ADDR_ENTRIES + 1);
	localparam int PIW = $clog2(PORT_ENTRIES);
	localparam int PCW = $clog2(PORT_ENTRIES + 1);
	localparam int XW  = (ACW > PCW) ? ACW : PCW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD,
		ST_EX_RD,
		ST_EX_WR,
		ST_EX_EMPTY
	} state_t;

	state_t          state_q;
	logic            step_q;
	logic [31:0]     own_ip_q;
	logic            own_en_q;
	in_word_t        item_q;
	out_word_t       out_q;
	logic            out_valid_q;

	logic [31:0]     addr_keys_q [ADDR_ENTRIES];
	logic [15:0]     port_keys_q [PORT_ENTRIES];
	logic [31:0]     addr_cnt_mem [ADDR_ENTRIES];
	logic [31:0]     port_cnt_mem [PORT_ENTRIES];
	logic [ACW-1:0]  addr_used_q;
	logic [PCW-1:0]  port_used_q;
	logic [31:0]     addr_rd_q;
	logic [31:0]     port_rd_q;
	logic            a_upd_q;
	logic            p_upd_q;
	logic [AIW-1:0]  a_idx_q;
	logic [PIW-1:0]  p_idx_q;
	logic            ex_port_q;
	logic [XW-1:0]   ex_idx_q;

	logic [31:0]     a_key;
	logic [15:0]     p_key;
	logic            a_hit;
	logic            p_hit;
	logic [AIW-1:0]  a_hidx;
	logic [PIW-1:0]  p_hidx;
	logic            a_room;
	logic            p_room;
	logic            skip;
	logic            out_free;
	logic            out_load;
	logic [XW-1:0]   ex_nxt;
	logic            ex_end_a;
	logic            ex_end_p;
	logic            ex_last;
	out_word_t       ex_rec;

	logic            a_we;
	logic [AIW-1:0]  a_waddr;
	logic [31:0]     a_wdata;
	logic            a_re;
	logic [AIW-1:0]  a_raddr;
	logic            p_we;
	logic [PIW-1:0]  p_waddr;
	logic [31:0]     p_wdata;
	logic            p_re;
	logic [PIW-1:0]  p_raddr;

	assign items.ready   = (state_q == ST_IDLE);
	assign records.valid = out_valid_q;
	assign records.data  = out_q;
	assign out_free      = !out_valid_q || records.ready;
	assign out_load      = out_free && (state_q inside {ST_EX_WR, ST_EX_EMPTY});

	assign skip = (own_en_q && (items.data.src_ip_addr == own_ip_q ||
		items.data.dst_ip_addr == own_ip_q)) || (items.data.payload_len == 16'd0);

	assign a_key  = step_q ? item_q.dst_ip_addr : item_q.src_ip_addr;
	assign p_key  = step_q ? item_q.dst_tcp_port : item_q.src_tcp_port;
	assign a_room = addr_used_q < ACW'(ADDR_ENTRIES);
	assign p_room = port_used_q < PCW'(PORT_ENTRIES);

	always_comb begin
		a_hit  = 1'b0;
		a_hidx = '0;
		for (int i = 0; i < ADDR_ENTRIES; i++) begin
			if (ACW'(i) < addr_used_q && addr_keys_q[i] == a_key) begin
				a_hit  = 1'b1;
				a_hidx = a_hidx | AIW'(i);
			end
		end
	end

	always_comb begin
		p_hit  = 1'b0;
		p_hidx = '0;
		for (int i = 0; i < PORT_ENTRIES; i++) begin
			if (PCW'(i) < port_used_q && port_keys_q[i] == p_key) begin
				p_hit  = 1'b1;
				p_hidx = p_hidx | PIW'(i);
			end
		end
	end

	// count memory access: append or read in lookup, write back in update, read in export
	always_comb begin
		a_we    = 1'b0;
		a_waddr = addr_used_q[AIW-1:0];
		a_wdata = {16'd0, item_q.payload_len};
		a_re    = 1'b0;
		a_raddr = a_hidx;
		p_we    = 1'b0;
		p_waddr = port_used_q[PIW-1:0];
		p_wdata = {16'd0, item_q.payload_len};
		p_re    = 1'b0;
		p_raddr = p_hidx;
		case (state_q)
			ST_LOOK: begin
				a_we = !a_hit && a_room;
				a_re = a_hit;
				p_we = !p_hit && p_room;
				p_re = p_hit;
			end
			ST_UPD: begin
				a_we    = a_upd_q;
				a_waddr = a_idx_q;
				a_wdata = addr_rd_q + {16'd0, item_q.payload_len};
				p_we    = p_upd_q;
				p_waddr = p_idx_q;
				p_wdata = port_rd_q + {16'd0, item_q.payload_len};
			end
			ST_EX_RD: begin
				a_re    = !ex_port_q;
				a_raddr = ex_idx_q[AIW-1:0];
				p_re    = ex_port_q;
				p_raddr = ex_idx_q[PIW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			addr_cnt_mem[a_waddr] <= a_wdata;
		end
		if (a_re) begin
			addr_rd_q <= addr_cnt_mem[a_raddr];
		end
		if (p_we) begin
			port_cnt_mem[p_waddr] <= p_wdata;
		end
		if (p_re) begin
			port_rd_q <= port_cnt_mem[p_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_q <= items.data;
		end
		if (state_q == ST_LOOK) begin
			a_idx_q <= a_hidx;
			p_idx_q <= p_hidx;
			if (!a_hit && a_room) begin
				addr_keys_q[addr_used_q[AIW-1:0]] <= a_key;
			end
			if (!p_hit && p_room) begin
				port_keys_q[port_used_q[PIW-1:0]] <= p_key;
			end
		end
	end

	assign ex_nxt   = ex_idx_q + XW'(1);
	assign ex_end_a = !ex_port_q && ex_nxt == XW'(addr_used_q);
	assign ex_end_p = ex_port_q && ex_nxt == XW'(port_used_q);
	assign ex_last  = ex_end_p || (ex_end_a && port_used_q == '0);

	always_comb begin
		ex_rec.last = ex_last;
		if (ex_port_q) begin
			ex_rec.record_kind = KIND_PORT;
			ex_rec.record_key  = {16'd0, port_keys_q[ex_idx_q[PIW-1:0]]};
			ex_rec.byte_total  = port_rd_q;
		end else begin
			ex_rec.record_kind = KIND_ADDR;
			ex_rec.record_key  = addr_keys_q[ex_idx_q[AIW-1:0]];
			ex_rec.byte_total  = addr_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q <= '0;
			own_en_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_OWN_IP_ADDR:      own_ip_q <= wr_data;
				REG_OWN_CHECK_ENABLE: own_en_q <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= 1'b0;
			addr_used_q <= '0;
			port_used_q <= '0;
			a_upd_q     <= 1'b0;
			p_upd_q     <= 1'b0;
			ex_port_q   <= 1'b0;
			ex_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (records.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (items.valid) begin
						if (items.data.operation == OP_EXPORT) begin
							ex_idx_q  <= '0;
							ex_port_q <= (addr_used_q == '0);
							if (addr_used_q == '0 && port_used_q == '0) begin
								state_q <= ST_EX_EMPTY;
							end else begin
								state_q <= ST_EX_RD;
							end
						end else if (!skip) begin
							step_q  <= 1'b0;
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					a_upd_q <= a_hit;
					p_upd_q <= p_hit;
					if (!a_hit && a_room) begin
						addr_used_q <= addr_used_q + ACW'(1);
					end
					if (!p_hit && p_room) begin
						port_used_q <= port_used_q + PCW'(1);
					end
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (!step_q) begin
						step_q  <= 1'b1;
						state_q <= ST_LOOK;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EX_RD: begin
					state_q <= ST_EX_WR;
				end
				ST_EX_WR: begin
					if (out_free) begin
						out_q <= ex_rec;
						if (ex_last) begin
							addr_used_q <= '0;
							port_used_q <= '0;
							state_q     <= ST_IDLE;
						end else if (ex_end_a) begin
							ex_port_q <= 1'b1;
							ex_idx_q  <= '0;
							state_q   <= ST_EX_RD;
						end else begin
							ex_idx_q <= ex_nxt;
							state_q  <= ST_EX_RD;
						end
					end
				end
				ST_EX_EMPTY: begin
					if (out_free) begin
						out_q.record_kind  <= KIND_EMPTY;
						out_q.record_key   <= '0;
						out_q.byte_total   <= '0;
						out_q.last         <= 1'b1;
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/ipba_checker.sv =====
// ----------------------------------------------------------------------------
// ipba_checker
// Port-level checks for the IP address and port byte accounting block.
// ----------------------------------------------------------------------------
module ipba_checker import ipba_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_word_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_word_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("record word changed while stalled");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.record_kind == KIND_EMPTY |-> out_data.last)
		else $error("empty marker without last");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.record_kind == KIND_ADDR ||
			out_data.record_kind == KIND_PORT || out_data.record_kind == KIND_EMPTY)
		else $error("undefined record kind");

	a_export_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.operation == OP_EXPORT |=> !in_ready)
		else $error("item taken while export starts");

	a_port_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_data.record_kind == KIND_PORT && !out_data.last
		|=> !(out_valid && out_data.record_kind == KIND_ADDR))
		else $error("address record inside port section");

endmodule

bind ip_port_byte_accounting ipba_checker u_ipba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_data   (items.data),
	.out_valid (records.valid),
	.out_ready (records.ready),
	.out_data  (records.data)
);

// ===== bench/ipba_ledger_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipba_ledger_checker
// Watches the packet and record channels and the register port, keeps its own
// address and port byte ledgers, and compares every export record field by
// field against the ledger contents in first-appearance order.
// ----------------------------------------------------------------------------
module ipba_ledger_checker import ipba_pkg::*; #(
	parameter int ADDR_ENTRIES = 16,
	parameter int PORT_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  in_word_t              item_data,
	input  logic                  rec_valid,
	input  logic                  rec_ready,
	input  out_word_t             rec_data,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output int                    fail_count,
	output int                    pending,
	output int                    records_checked,
	output int                    exports_seen
);
	logic [31:0] own_addr;
	logic        own_check_en;
	logic [31:0] addr_key_tbl [ADDR_ENTRIES];
	logic [31:0] addr_sum_tbl [ADDR_ENTRIES];
	logic [15:0] port_key_tbl [PORT_ENTRIES];
	logic [31:0] port_sum_tbl [PORT_ENTRIES];
	int          addr_fill;
	int          port_fill;
	int          errors = 0;
	out_word_t   owed_records [$];

	assign fail_count = errors;

	function void tally_addr(logic [31:0] key, logic [31:0] bytes);
		for (int i = 0; i < addr_fill; i++) begin
			if (addr_key_tbl[i] == key) begin
				addr_sum_tbl[i] = addr_sum_tbl[i] + bytes;
				return;
			end
		end
		if (addr_fill < ADDR_ENTRIES) begin
			addr_key_tbl[addr_fill] = key;
			addr_sum_tbl[addr_fill] = bytes;
			addr_fill++;
		end
	endfunction

	function void tally_port(logic [15:0] key, logic [31:0] bytes);
		for (int i = 0; i < port_fill; i++) begin
			if (port_key_tbl[i] == key) begin
				port_sum_tbl[i] = port_sum_tbl[i] + bytes;
				return;
			end
		end
		if (port_fill < PORT_ENTRIES) begin
			port_key_tbl[port_fill] = key;
			port_sum_tbl[port_fill] = bytes;
			port_fill++;
		end
	endfunction

	function void owe(kind_t kind, logic [31:0] key, logic [31:0] bytes, logic last_flag);
		out_word_t rec;
		rec.record_kind = kind;
		rec.record_key  = key;
		rec.byte_total  = bytes;
		rec.last        = last_flag;
		owed_records.push_back(rec);
	endfunction

	function void dump_ledgers();
		int total;
		int k;
		total = addr_fill + port_fill;
		k = 0;
		if (total == 0)
			owe(KIND_EMPTY, '0, '0, 1'b1);
		for (int i = 0; i < addr_fill; i++) begin
			k++;
			owe(KIND_ADDR, addr_key_tbl[i], addr_sum_tbl[i], k == total);
		end
		for (int i = 0; i < port_fill; i++) begin
			k++;
			owe(KIND_PORT, {16'd0, port_key_tbl[i]}, port_sum_tbl[i], k == total);
		end
		addr_fill = 0;
		port_fill = 0;
	endfunction

	function void account(in_word_t w);
		logic [31:0] bytes;
		bytes = {16'd0, w.payload_len};
		if (own_check_en && (w.src_ip_addr == own_addr || w.dst_ip_addr == own_addr))
			return;
		if (w.payload_len == 16'd0)
			return;
		tally_addr(w.src_ip_addr, bytes);
		tally_addr(w.dst_ip_addr, bytes);
		tally_port(w.src_tcp_port, bytes);
		tally_port(w.dst_tcp_port, bytes);
	endfunction

	function void note(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= 10)
			$display("record %0d: %s expected %h, got %h", records_checked, field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			own_addr = '0;
			own_check_en = 1'b0;
			addr_fill = 0;
			port_fill = 0;
			records_checked = 0;
			exports_seen = 0;
			owed_records.delete();
			pending <= 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_OWN_IP_ADDR: own_addr = wr_data;
					REG_OWN_CHECK_ENABLE: own_check_en = wr_data[0];
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				if (item_data.operation == OP_EXPORT) begin
					exports_seen++;
					dump_ledgers();
				end else
					account(item_data);
			end
			if (rec_valid && rec_ready) begin
				if (owed_records.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected record: kind %0d key %h total %h last %b",
							rec_data.record_kind, rec_data.record_key,
							rec_data.byte_total, rec_data.last);
				end else begin
					want = owed_records.pop_front();
					if (rec_data.record_kind !== want.record_kind)
						note("record_kind", {30'd0, want.record_kind},
							{30'd0, rec_data.record_kind});
					if (rec_data.record_key !== want.record_key)
						note("record_key", want.record_key, rec_data.record_key);
					if (rec_data.byte_total !== want.byte_total)
						note("byte_total", want.byte_total, rec_data.byte_total);
					if (rec_data.last !== want.last)
						note("last", {31'd0, want.last}, {31'd0, rec_data.last});
				end
				records_checked++;
			end
			pending <= owed_records.size();
		end
	end

endmodule

// ===== bench/ip_port_byte_accounting_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_port_byte_accounting_tb
// Drives packet and export words into the byte accounting block with random
// gaps and record stalls, across several own-address settings; a separate
// checker predicts every export record and counts mismatches.
// ----------------------------------------------------------------------------
module ip_port_byte_accounting_tb;
	import ipba_pkg::*;

	localparam int ADDR_ENTRIES  = 16;
	localparam int PORT_ENTRIES  = 16;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_WORDS = 45;
	localparam int POOL_MAX      = 24;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	logic                  quiet;
	int                    cycle_count = 0;
	int                    words_sent = 0;
	int                    fail_count;
	int                    pending;
	int                    records_checked;
	int                    exports_seen;
	logic [31:0]           addr_pool [POOL_MAX];
	logic [15:0]           port_pool [POOL_MAX];
	int                    pool_n = 1;

	ipba_stream_if #(.word_t(in_word_t))  items_if ();
	ipba_stream_if #(.word_t(out_word_t)) records_if ();

	always #2 clk = ~clk;

	ip_port_byte_accounting #(
		.ADDR_ENTRIES(ADDR_ENTRIES),
		.PORT_ENTRIES(PORT_ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.records(records_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	ipba_ledger_checker #(
		.ADDR_ENTRIES(ADDR_ENTRIES),
		.PORT_ENTRIES(PORT_ENTRIES)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(items_if.valid),
		.item_ready(items_if.ready),
		.item_data(items_if.data),
		.rec_valid(records_if.valid),
		.rec_ready(records_if.ready),
		.rec_data(records_if.data),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.fail_count(fail_count),
		.pending(pending),
		.records_checked(records_checked),
		.exports_seen(exports_seen)
	);

	function automatic int draw_wait();
		if (quiet)
			return 0;
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(0, 14);
		return $urandom_range(0, 1);
	endfunction

	function automatic in_word_t account_word(logic [31:0] src, logic [31:0] dst,
		logic [15:0] sport, logic [15:0] dport, logic [15:0] len);
		in_word_t w;
		w.operation    = OP_ACCOUNT;
		w.src_ip_addr  = src;
		w.dst_ip_addr  = dst;
		w.src_tcp_port = sport;
		w.dst_tcp_port = dport;
		w.payload_len  = len;
		return w;
	endfunction

	function automatic in_word_t export_word();
		in_word_t w;
		w.operation    = OP_EXPORT;
		w.src_ip_addr  = $urandom;
		w.dst_ip_addr  = $urandom;
		w.src_tcp_port = 16'($urandom);
		w.dst_tcp_port = 16'($urandom);
		w.payload_len  = 16'($urandom);
		return w;
	endfunction

	function automatic logic [31:0] pick_addr();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return addr_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom);
		return port_pool[$urandom_range(0, pool_n - 1)];
	endfunction

	function automatic logic [15:0] pick_len();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(1, 65535));
		endcase
	endfunction

	task automatic push_word(in_word_t w);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			items_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.data <= w;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		words_sent++;
	endtask

	// hold the sender until every owed record is back, then let the block settle
	task automatic drain(int holdoff);
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (holdoff) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	initial begin
		quiet <= 1'b0;
		forever begin
			repeat (64) @(posedge clk);
			quiet <= ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : record_sink
		int stall;
		stall = 0;
		records_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (records_if.valid && records_if.ready)
				stall = draw_wait();
			if (stall > 0) begin
				records_if.ready <= 1'b0;
				stall--;
			end else
				records_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d records still owed", cycle_count, pending);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic [31:0] own;
		logic        en;
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		items_if.valid <= 1'b0;
		items_if.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_OWN_IP_ADDR, 32'hC0A80001);
		write_reg(REG_OWN_CHECK_ENABLE, 32'd1);

		push_word(export_word());
		push_word(account_word(32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF, 16'hFFFF));
		push_word(account_word(32'h0A000001, 32'h0A000001, 16'd80, 16'd80, 16'd1));
		push_word(account_word(32'h0A000002, 32'h0A000003, 16'd81, 16'd82, 16'd0));
		push_word(account_word(32'hC0A80001, 32'h0A000004, 16'd83, 16'd84, 16'd100));
		push_word(account_word(32'h0A000005, 32'hC0A80001, 16'd85, 16'd86, 16'd100));
		// fill both tables; the last pair overflows by one key
		for (int i = 0; i < 7; i++)
			push_word(account_word(32'h0B000000 + 32'(2 * i), 32'h0B000001 + 32'(2 * i),
				16'(1000 + 2 * i), 16'(1001 + 2 * i), 16'($urandom_range(1, 65535))));
		push_word(account_word(32'h0B000000, 32'h0C000000, 16'd1000, 16'd5555, 16'd7));
		push_word(export_word());
		push_word(export_word());
		drain(8);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			own = (seg == 0) ? 32'h0 : (seg == 1) ? 32'hFFFFFFFF : $urandom;
			en = (seg == 2) ? 1'b0 : (seg < 2) ? 1'b1 : 1'($urandom_range(0, 1));
			write_reg(REG_OWN_IP_ADDR, own);
			write_reg(REG_OWN_CHECK_ENABLE, {31'($urandom), en});
			pool_n = $urandom_range(3, POOL_MAX);
			for (int j = 0; j < POOL_MAX; j++) begin
				addr_pool[j] = $urandom;
				port_pool[j] = 16'($urandom);
			end
			addr_pool[0] = own;
			for (int n = 0; n < SEGMENT_WORDS; n++) begin
				if (n == SEGMENT_WORDS - 1 || $urandom_range(0, 11) == 0)
					push_word(export_word());
				else
					push_word(account_word(pick_addr(), pick_addr(), pick_port(),
						pick_port(), pick_len()));
			end
			drain(8);
		end
		repeat (16) @(posedge clk);

		$display("sent %0d packet and export words under %0d own-address settings",
			words_sent, SEGMENTS + 1);
		$display("%0d exports, %0d records compared, %0d mismatches",
			exports_seen, records_checked, fail_count);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
